// File: hw/rtl/cpml_pkg.sv
// cpml_pkg: shared types and constants of the column projection minimum locator
// register indexes, reset values, field widths, queue geometry, item flags
// no dependencies
`default_nettype none

package cpml_pkg;

  // field widths fixed by the interface
  localparam int PIX_W   = 8;
  localparam int SUM_W   = 14;
  localparam int OCOL_W  = 10;
  localparam int POS_W   = 14;
  localparam int CFG_W   = 11;
  localparam int CIDX_W  = 2;
  localparam int SW_W    = 11;
  localparam int SR_W    = 7;
  localparam int LEN_W   = 10;
  localparam int SHIFT_W = 11;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_STRIP_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_STRIP_ROWS   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_RAIL_LENGTH  = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_CENTER_SHIFT = 2'd3;

  // configuration reset values
  localparam logic [SW_W-1:0]           RST_STRIP_WIDTH  = 11'd640;
  localparam logic [SR_W-1:0]           RST_STRIP_ROWS   = 7'd3;
  localparam logic [LEN_W-1:0]          RST_RAIL_LENGTH  = 10'd300;
  localparam logic signed [SHIFT_W-1:0] RST_CENTER_SHIFT = -11'sd36;

  localparam logic [SUM_W-1:0]        SUM_MAX = 14'h3FFF;
  localparam logic signed [POS_W-1:0] POS_MIN = -14'sd8192;
  localparam logic signed [POS_W-1:0] POS_MAX = 14'sd8191;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef struct packed {
    logic first_row;
    logic last_row;
    logic frame_end;
  } cpml_flags_t;

endpackage

`default_nettype wire

// File: hw/rtl/cpml_front.sv
// cpml_front: accepts pixel items, keeps the column and row counters
// and tags each item with its column and row position flags; uses cpml_pkg
`default_nettype none

module cpml_front #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 64,
  localparam int COL_W = $clog2(MAX_COLUMNS),
  localparam int W_W   = $clog2(MAX_COLUMNS + 1),
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int R_W   = $clog2(MAX_ROWS + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [cpml_pkg::PIX_W-1:0] in_pixel,
  input  logic                       in_frame_start,
  input  logic [W_W-1:0]             eff_w,
  input  logic [R_W-1:0]             eff_r,
  input  logic                       q_full,
  output logic                       push,
  output logic [cpml_pkg::PIX_W-1:0] push_pixel,
  output logic [COL_W-1:0]           push_col,
  output cpml_pkg::cpml_flags_t      push_flags
);

  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             last_col;
  logic             last_row;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign col = in_frame_start ? '0 : col_cnt_r;
  assign row = in_frame_start ? '0 : row_cnt_r;

  // a shrunk width or row count ends the row or frame early
  assign last_col = ((W_W+1)'(col) + (W_W+1)'(1)) >= (W_W+1)'(eff_w);
  assign last_row = ((R_W+1)'(row) + (R_W+1)'(1)) >= (R_W+1)'(eff_r);

  assign push_pixel           = in_pixel;
  assign push_col             = col;
  assign push_flags.first_row = (row == '0);
  assign push_flags.last_row  = last_row;
  assign push_flags.frame_end = last_col && last_row;

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (push) begin
      col_cnt_nxt = last_col ? '0 : col + COL_W'(1);
      row_cnt_nxt = row;
      if (last_col) begin
        row_cnt_nxt = last_row ? '0 : row + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cpml_queue.sv
// cpml_queue: short first-in first-out queue of tagged pixel items
// between the front and the back; uses cpml_pkg
`default_nettype none

module cpml_queue #(
  parameter int COL_W = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [cpml_pkg::PIX_W-1:0] push_pixel,
  input  logic [COL_W-1:0]           push_col,
  input  cpml_pkg::cpml_flags_t      push_flags,
  output logic                       full,
  input  logic                       pop,
  output logic                       head_valid,
  output logic [cpml_pkg::PIX_W-1:0] head_pixel,
  output logic [COL_W-1:0]           head_col,
  output cpml_pkg::cpml_flags_t      head_flags
);

  localparam int AW = cpml_pkg::Q_AW;

  logic [cpml_pkg::PIX_W-1:0] pix_r   [cpml_pkg::Q_DEPTH];
  logic [COL_W-1:0]           col_r   [cpml_pkg::Q_DEPTH];
  cpml_pkg::cpml_flags_t      flags_r [cpml_pkg::Q_DEPTH];
  logic [AW-1:0]              wr_ptr_r, rd_ptr_r;
  logic [AW:0]                cnt_r, cnt_nxt;

  assign full       = (cnt_r == (AW+1)'(cpml_pkg::Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_pixel = pix_r[rd_ptr_r];
  assign head_col   = col_r[rd_ptr_r];
  assign head_flags = flags_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + (AW+1)'(1);
      2'b01:   cnt_nxt = cnt_r - (AW+1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      pix_r[wr_ptr_r]   <= push_pixel;
      col_r[wr_ptr_r]   <= push_col;
      flags_r[wr_ptr_r] <= push_flags;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cpml_back.sv
// cpml_back: column sum memory with read-modify-write pipeline and the
// running minimum of the last row; hands the frame result to cpml_pos; uses cpml_pkg
`default_nettype none

module cpml_back #(
  parameter int MAX_COLUMNS = 1024,
  localparam int COL_W = $clog2(MAX_COLUMNS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  logic [cpml_pkg::PIX_W-1:0] q_pixel,
  input  logic [COL_W-1:0]           q_col,
  input  cpml_pkg::cpml_flags_t      q_flags,
  output logic                       q_pop,
  input  logic                       unit_idle,
  output logic                       start,
  output logic [COL_W-1:0]           start_col,
  output logic [cpml_pkg::SUM_W-1:0] start_sum
);

  localparam int SW = cpml_pkg::SUM_W;

  logic [SW-1:0]              sums_mem [MAX_COLUMNS];
  logic [SW-1:0]              rd_r;
  logic                       s2_valid_r;
  logic [cpml_pkg::PIX_W-1:0] s2_pix_r;
  logic [COL_W-1:0]           s2_col_r;
  cpml_pkg::cpml_flags_t      s2_flags_r;
  logic                       fwd_r;
  logic [SW-1:0]              fwd_sum_r;
  logic [SW-1:0]              best_sum_r;
  logic [COL_W-1:0]           best_col_r;
  logic [SW-1:0]              base;
  logic [SW:0]                ext;
  logic [SW-1:0]              sum;
  logic                       upd;

  // a frame end waits until the position unit is free for it
  assign q_pop = q_valid && (!q_flags.frame_end ||
                 (unit_idle && !(s2_valid_r && s2_flags_r.frame_end)));

  // the item written in the cycle of the read is forwarded around the memory
  assign base = fwd_r ? fwd_sum_r : rd_r;
  assign ext  = {1'b0, base} + (SW+1)'(s2_pix_r);
  always_comb begin
    if (s2_flags_r.first_row) begin
      sum = SW'(s2_pix_r);
    end else if (ext[SW]) begin
      sum = cpml_pkg::SUM_MAX;
    end else begin
      sum = ext[SW-1:0];
    end
  end

  // first column of the last row always loads, later ones only when strictly lower
  assign upd = s2_valid_r && s2_flags_r.last_row &&
               ((s2_col_r == '0) || (sum < best_sum_r));

  assign start     = s2_valid_r && s2_flags_r.frame_end;
  assign start_col = upd ? s2_col_r : best_col_r;
  assign start_sum = upd ? sum : best_sum_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_r <= sums_mem[q_col];
    end
    if (s2_valid_r) begin
      sums_mem[s2_col_r] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_pix_r   <= q_pixel;
      s2_col_r   <= q_col;
      s2_flags_r <= q_flags;
      fwd_r      <= s2_valid_r && (s2_col_r == q_col);
      fwd_sum_r  <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      best_sum_r <= cpml_pkg::SUM_MAX;
      best_col_r <= '0;
    end else begin
      s2_valid_r <= q_pop;
      if (upd) begin
        best_sum_r <= sum;
        best_col_r <= s2_col_r;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cpml_pos.sv
// cpml_pos: per-frame position unit: offset, multiply, restoring division
// one quotient bit a cycle, saturation and the result register; uses cpml_pkg
`default_nettype none

module cpml_pos #(
  parameter int MAX_COLUMNS = 1024,
  localparam int COL_W = $clog2(MAX_COLUMNS),
  localparam int W_W   = $clog2(MAX_COLUMNS + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [COL_W-1:0]                  start_col,
  input  logic [cpml_pkg::SUM_W-1:0]        start_sum,
  input  logic [W_W-1:0]                    eff_w,
  input  logic [cpml_pkg::LEN_W-1:0]        rail_length,
  input  logic signed [cpml_pkg::SHIFT_W-1:0] center_shift,
  output logic                              idle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cpml_pkg::OCOL_W-1:0]       out_min_column,
  output logic [cpml_pkg::SUM_W-1:0]        out_min_sum,
  output logic signed [cpml_pkg::POS_W-1:0] out_position_tenths_mm
);

  localparam int PROD_W = COL_W + cpml_pkg::LEN_W;
  localparam int NUM_W  = PROD_W + 4;
  localparam int P_W    = NUM_W + 2;
  localparam int CNT_W  = $clog2(NUM_W);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_SCL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } pos_state_t;

  pos_state_t          state_r, state_nxt;
  logic [COL_W-1:0]    col_r;
  logic [cpml_pkg::SUM_W-1:0] sum_r;
  logic                neg_r;
  logic [COL_W-1:0]    dmag_r;
  logic [PROD_W-1:0]   prod_r;
  logic [NUM_W-1:0]    quo_r;
  logic [W_W-1:0]      rem_r;
  logic [CNT_W-1:0]    cnt_r;
  logic signed [W_W:0] d;
  logic [W_W:0]        trial;
  logic                ge;
  logic signed [P_W-1:0] qs;
  logic signed [P_W-1:0] p;
  logic signed [cpml_pkg::POS_W-1:0] p_sat;

  assign idle      = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // signed distance of the column from the strip center
  assign d = $signed({1'b0, W_W'(start_col)}) - $signed({1'b0, eff_w >> 1});

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign ge    = (trial >= (W_W+1)'(eff_w));

  always_comb begin
    qs = $signed(P_W'(quo_r));
    if (neg_r) begin
      qs = -qs;
    end
    p = qs + P_W'(center_shift);
    if (p < P_W'(cpml_pkg::POS_MIN)) begin
      p_sat = cpml_pkg::POS_MIN;
    end else if (p > P_W'(cpml_pkg::POS_MAX)) begin
      p_sat = cpml_pkg::POS_MAX;
    end else begin
      p_sat = cpml_pkg::POS_W'(p);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SCL;
      S_SCL:  state_nxt = S_DIV;
      S_DIV:  if (cnt_r == '0) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          col_r  <= start_col;
          sum_r  <= start_sum;
          neg_r  <= d[W_W];
          dmag_r <= d[W_W] ? COL_W'(-d) : COL_W'(d);
        end
      end
      S_MUL: begin
        prod_r <= PROD_W'(dmag_r) * PROD_W'(rail_length);
      end
      S_SCL: begin
        // times ten as 8x + 2x
        quo_r <= NUM_W'({prod_r, 3'b000}) + NUM_W'({prod_r, 1'b0});
        rem_r <= '0;
        cnt_r <= CNT_W'(NUM_W - 1);
      end
      S_DIV: begin
        rem_r <= ge ? W_W'(trial - (W_W+1)'(eff_w)) : W_W'(trial);
        quo_r <= {quo_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      S_FIN: begin
        out_min_column         <= cpml_pkg::OCOL_W'(col_r);
        out_min_sum            <= sum_r;
        out_position_tenths_mm <= p_sat;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/column_projection_min_locator.sv
// column_projection_min_locator: top level, configuration registers and the
// front / queue / back / position unit chain; uses cpml_pkg and all cpml_ modules
//
//  port group  direction  handshake          payload
//  in_         sink       in_valid/in_stall  in_pixel, in_frame_start
//  out_        source     out_valid/out_stall out_min_column, out_min_sum,
//                                            out_position_tenths_mm
//  cfg_        sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// one pixel item per cycle while in_stall is low; each item passes through the sum
// memory read-modify-write after the 4-entry queue
// after the last pixel leaves the queue the result passes the multiply, scale,
// one-bit-a-cycle divide and finish states; it overlaps the next frame's pixels
// a new frame end waits in the queue while the position unit or result is busy
// synchronous active-low reset; column sums are not cleared, the first row overwrites
`default_nettype none

module column_projection_min_locator #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [cpml_pkg::PIX_W-1:0]         in_pixel,
  input  logic                               in_frame_start,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cpml_pkg::OCOL_W-1:0]        out_min_column,
  output logic [cpml_pkg::SUM_W-1:0]         out_min_sum,
  output logic signed [cpml_pkg::POS_W-1:0]  out_position_tenths_mm,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cpml_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [cpml_pkg::CFG_W-1:0]         cfg_data
);

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int W_W    = $clog2(MAX_COLUMNS + 1);
  localparam int R_W    = $clog2(MAX_ROWS + 1);
  localparam int WCMP_W = (W_W > cpml_pkg::SW_W) ? W_W : cpml_pkg::SW_W;
  localparam int RCMP_W = (R_W > cpml_pkg::SR_W) ? R_W : cpml_pkg::SR_W;

  logic [cpml_pkg::SW_W-1:0]           strip_width_r;
  logic [cpml_pkg::SR_W-1:0]           strip_rows_r;
  logic [cpml_pkg::LEN_W-1:0]          rail_length_r;
  logic signed [cpml_pkg::SHIFT_W-1:0] center_shift_r;
  logic [W_W-1:0]                      eff_w;
  logic [R_W-1:0]                      eff_r;

  logic                       push;
  logic [cpml_pkg::PIX_W-1:0] push_pixel;
  logic [COL_W-1:0]           push_col;
  cpml_pkg::cpml_flags_t      push_flags;
  logic                       q_full;
  logic                       q_pop;
  logic                       q_valid;
  logic [cpml_pkg::PIX_W-1:0] q_pixel;
  logic [COL_W-1:0]           q_col;
  cpml_pkg::cpml_flags_t      q_flags;
  logic                       unit_idle;
  logic                       start;
  logic [COL_W-1:0]           start_col;
  logic [cpml_pkg::SUM_W-1:0] start_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_width_r  <= cpml_pkg::RST_STRIP_WIDTH;
      strip_rows_r   <= cpml_pkg::RST_STRIP_ROWS;
      rail_length_r  <= cpml_pkg::RST_RAIL_LENGTH;
      center_shift_r <= cpml_pkg::RST_CENTER_SHIFT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cpml_pkg::CFG_STRIP_WIDTH:  strip_width_r  <= cfg_data[cpml_pkg::SW_W-1:0];
        cpml_pkg::CFG_STRIP_ROWS:   strip_rows_r   <= cfg_data[cpml_pkg::SR_W-1:0];
        cpml_pkg::CFG_RAIL_LENGTH:  rail_length_r  <= cfg_data[cpml_pkg::LEN_W-1:0];
        cpml_pkg::CFG_CENTER_SHIFT: center_shift_r <= $signed(cfg_data[cpml_pkg::SHIFT_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // width and rows clamped to at least one and to what the storage holds
  always_comb begin
    if (strip_width_r == '0) begin
      eff_w = W_W'(1);
    end else if (WCMP_W'(strip_width_r) > WCMP_W'(MAX_COLUMNS)) begin
      eff_w = W_W'(MAX_COLUMNS);
    end else begin
      eff_w = W_W'(strip_width_r);
    end
    if (strip_rows_r == '0) begin
      eff_r = R_W'(1);
    end else if (RCMP_W'(strip_rows_r) > RCMP_W'(MAX_ROWS)) begin
      eff_r = R_W'(MAX_ROWS);
    end else begin
      eff_r = R_W'(strip_rows_r);
    end
  end

  cpml_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel      (in_pixel),
    .in_frame_start(in_frame_start),
    .eff_w         (eff_w),
    .eff_r         (eff_r),
    .q_full        (q_full),
    .push          (push),
    .push_pixel    (push_pixel),
    .push_col      (push_col),
    .push_flags    (push_flags)
  );

  cpml_queue #(
    .COL_W(COL_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_pixel(push_pixel),
    .push_col  (push_col),
    .push_flags(push_flags),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_pixel(q_pixel),
    .head_col  (q_col),
    .head_flags(q_flags)
  );

  cpml_back #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pixel  (q_pixel),
    .q_col    (q_col),
    .q_flags  (q_flags),
    .q_pop    (q_pop),
    .unit_idle(unit_idle),
    .start    (start),
    .start_col(start_col),
    .start_sum(start_sum)
  );

  cpml_pos #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_pos (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .start_col             (start_col),
    .start_sum             (start_sum),
    .eff_w                 (eff_w),
    .rail_length           (rail_length_r),
    .center_shift          (center_shift_r),
    .idle                  (unit_idle),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_min_column        (out_min_column),
    .out_min_sum           (out_min_sum),
    .out_position_tenths_mm(out_position_tenths_mm)
  );

endmodule

`default_nettype wire

// File: hw/rtl/cpml_checker.sv
// cpml_checker: port-level assertions for column_projection_min_locator
// bound to the top level below; uses only the top-level ports
`default_nettype none

module cpml_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [9:0]  out_min_column,
  input logic [13:0] out_min_sum,
  input logic [13:0] out_position_tenths_mm
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_min_column) &&
      $stable(out_min_sum) && $stable(out_position_tenths_mm))
    else $error("result changed while stalled");

  // the position unit passes its multiply, scale, divide and finish states before the next result
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("results closer than the position unit allows");

  // the queue is empty right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind column_projection_min_locator cpml_checker u_cpml_checker (.*);

`default_nettype wire
